### design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: commands, cell
// operations and the word type.
// ----------------------------------------------------------------------------
package deq_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [2:0] cmd_t;
  typedef logic [1:0] cell_op_t;

  localparam cmd_t CMD_PUSH_FRONT = 3'd0;
  localparam cmd_t CMD_PUSH_BACK  = 3'd1;
  localparam cmd_t CMD_POP_FRONT  = 3'd2;
  localparam cmd_t CMD_POP_BACK   = 3'd3;

  // what every cell does at the next edge
  localparam cell_op_t OP_HOLD       = 2'd0;
  localparam cell_op_t OP_SHIFT_UP   = 2'd1;  // take from lower neighbor
  localparam cell_op_t OP_SHIFT_DOWN = 2'd2;  // take from higher neighbor
  localparam cell_op_t OP_LOAD_BACK  = 2'd3;  // cell at count takes the word

  localparam word_t EMPTY_WORD = 32'shFFFFFFFF;

endpackage

### design/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words on a row of shifting cells.
// ----------------------------------------------------------------------------
// The queue takes one command beat per cycle while not stalled and returns one
// result beat for each via the pending and output registers; the front entry
// always sits in cell zero, so a front push or pop shifts the row by one place
// in that cycle, while a push at the back loads the cell at the fill count.
// The back entry is read through an or chain running down the row, and a
// result beat is formed from the row as it stands after its command. One
// result may wait in the output register while the next command is taken;
// input stalls only when a second result is waiting behind a stalled output.
// Rejected pushes on a full queue and pops on an empty one set op_error.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  word_t       push_value,
  output logic        out_valid,
  input  logic        out_stall,
  output word_t       pop_value,
  output word_t       front_value,
  output word_t       back_value,
  output logic        is_empty,
  output logic        is_full,
  output logic        op_error
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pending;
  word_t            pend_pop;
  logic             pend_err;

  word_t            cell_data  [DEPTH];
  word_t            back_chain [DEPTH+1];
  cell_op_t         op;
  cell_op_t         cell_op;
  word_t            pop_next;
  logic             err_next;
  logic             accept;
  logic             move;
  logic             empty_now;
  logic             full_now;

  assign empty_now = (count == '0);
  assign full_now  = (count == CNT_W'(DEPTH));
  assign move      = pending && (!out_valid || !out_stall);
  assign in_stall  = pending && !move;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    op         = OP_HOLD;
    count_next = count;
    pop_next   = '0;
    err_next   = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full_now) begin
          err_next = 1'b1;
        end else begin
          op         = OP_SHIFT_UP;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full_now) begin
          err_next = 1'b1;
        end else begin
          op         = OP_LOAD_BACK;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty_now) begin
          err_next = 1'b1;
          pop_next = EMPTY_WORD;
        end else begin
          op         = OP_SHIFT_DOWN;
          pop_next   = cell_data[0];
          count_next = count - CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty_now) begin
          err_next = 1'b1;
          pop_next = EMPTY_WORD;
        end else begin
          pop_next   = back_chain[DEPTH];
          count_next = count - CNT_W'(1);
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  assign cell_op       = accept ? op : OP_HOLD;
  assign back_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lower;
    word_t upper;
    if (i == 0) begin : g_first
      assign lower = push_value;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    deq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .count      (count),
      .push_value (push_value),
      .lower_data (lower),
      .upper_data (upper),
      .back_in    (back_chain[i]),
      .data       (cell_data[i]),
      .back_out   (back_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        pending <= 1'b1;
      end else if (move) begin
        pending <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_pop <= pop_next;
      pend_err <= err_next;
    end
  end

  // the row already holds the state after the pending beat's command
  always_ff @(posedge clk) begin
    if (move) begin
      pop_value   <= pend_pop;
      op_error    <= pend_err;
      front_value <= empty_now ? EMPTY_WORD : cell_data[0];
      back_value  <= empty_now ? EMPTY_WORD : back_chain[DEPTH];
      is_empty    <= empty_now;
      is_full     <= full_now;
    end
  end

endmodule

### design/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue chain. Holds one word, shifts with its
// neighbors, and puts its word on the back-read chain when it is the last
// occupied cell.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  cell_op_t         op,
  input  logic [CNT_W-1:0] count,
  input  word_t            push_value,
  input  word_t            lower_data,
  input  word_t            upper_data,
  input  word_t            back_in,
  output word_t            data,
  output word_t            back_out
);

  logic is_slot;
  logic is_last;

  assign is_slot = (count == CNT_W'(INDEX));
  assign is_last = (count == CNT_W'(INDEX + 1));

  always_ff @(posedge clk) begin
    case (op)
      OP_SHIFT_UP:   data <= lower_data;
      OP_SHIFT_DOWN: data <= upper_data;
      OP_LOAD_BACK: begin
        if (is_slot) begin
          data <= push_value;
        end
      end
      default: data <= data;
    endcase
  end

  // at most one cell matches, so an or along the chain acts as the back mux
  assign back_out = back_in | (is_last ? data : '0);

endmodule
